[rtl/pmst_pkg.sv]
// Shared types, codes, constants and the helper function of the peer misbehavior score table.
`timescale 1ns / 1ps
package pmst_pkg;

  // Number of peer slots and the index width that addresses them.
  localparam int unsigned PEERS = 64;
  localparam int unsigned IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;

  // Operation codes of the op field.
  localparam logic [2:0] OP_ATTACH   = 3'd0;
  localparam logic [2:0] OP_DETACH   = 3'd1;
  localparam logic [2:0] OP_PENALIZE = 3'd2;
  localparam logic [2:0] OP_COUNT    = 3'd3;
  localparam logic [2:0] OP_RESET    = 3'd4;
  localparam logic [2:0] OP_QUERY    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_PENALTY   = 2'd2;

  // Register reset values.
  localparam logic [15:0] THRESHOLD_RST = 16'd100;
  localparam logic [7:0]  LIMIT_RST     = 8'd10;
  localparam logic [7:0]  PENALTY_RST   = 8'd20;

  // Class of an accepted item as seen by the back end.
  typedef enum logic [2:0] {
    CLS_ATTACH,
    CLS_DETACH,
    CLS_PENALIZE,
    CLS_COUNT,
    CLS_RESET,
    CLS_QUERY,
    CLS_NONE
  } cls_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    cls_e             cls;
    logic [IDX_W-1:0] idx;
    logic [7:0]       penalty;
    logic             noban;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic        disconnect;
    logic [15:0] score;
    logic [7:0]  unconnecting_count;
  } res_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [7:0]  limit;
    logic [7:0]  penalty;
  } cfg_t;

  // Per-peer payload kept in the entry memory; presence lives in flip-flops.
  typedef struct packed {
    logic        noban;
    logic [15:0] score;
    logic        mark;
    logic [7:0]  count;
    logic        latched;
  } entry_t;

  typedef struct packed {
    logic [15:0] score;
    logic        newly;
  } pen_res_t;

  // Saturating score update and first-crossing detection.
  function automatic pen_res_t add_penalty(logic [15:0] prev_score, logic [7:0] amount,
                                           logic [15:0] thr, logic nb);
    pen_res_t    r;
    logic [16:0] sum;
    sum = {1'b0, prev_score} + {9'd0, amount};
    r.score = sum[16] ? 16'hFFFF : sum[15:0];
    r.newly = (r.score >= thr) && (prev_score < thr) && !nb;
    return r;
  endfunction

endpackage

[rtl/pmst_front.sv]
// Front end: accepts items, classifies them and holds them in a two-entry command queue.
`timescale 1ns / 1ps
module pmst_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    op_i,
  input  logic [5:0]    peer_i,
  input  logic [7:0]    penalty_i,
  input  logic          noban_i,
  output pmst_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i
);
  import pmst_pkg::*;

  cmd_t       cls_cmd;
  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  logic       in_range;

  assign in_range = (32'(peer_i) < PEERS);

  always_comb begin
    cls_cmd.idx     = IDX_W'(peer_i);
    cls_cmd.penalty = penalty_i;
    cls_cmd.noban   = noban_i;
    unique case (op_i)
      OP_ATTACH:   cls_cmd.cls = CLS_ATTACH;
      OP_DETACH:   cls_cmd.cls = CLS_DETACH;
      OP_PENALIZE: cls_cmd.cls = CLS_PENALIZE;
      OP_COUNT:    cls_cmd.cls = CLS_COUNT;
      OP_RESET:    cls_cmd.cls = CLS_RESET;
      default:     cls_cmd.cls = CLS_QUERY;  // query and the unused codes
    endcase
    // A slot beyond the table is absent for every operation.
    if (!in_range) begin
      cls_cmd.cls = CLS_NONE;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = accept ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, accept} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

[rtl/pmst_back.sv]
// Back end: entry memory, presence bits and the read-modify-write sequencer.
`timescale 1ns / 1ps
module pmst_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pmst_pkg::cfg_t cfg_i,
  input  pmst_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output pmst_pkg::res_t res_o
);
  import pmst_pkg::*;

  bk_state_e      state_q, state_d;
  logic [PEERS-1:0] present_q;
  entry_t         mem_q [PEERS];
  entry_t         rdata_q;
  entry_t         wdata;
  logic           rd_en;
  logic           wr_en;
  logic           set_present;
  logic           clr_present;
  logic           pres;
  logic [7:0]     cnt_inc;
  pen_res_t       pr;

  assign pres = present_q[cmd_i.idx];

  // Sequencer: read the entry, then modify, write back and emit the result.
  always_comb begin
    state_d    = state_q;
    rd_en      = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          rd_en   = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        cmd_pop_o  = 1'b1;
        res_push_o = 1'b1;
        state_d    = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Entry update for the command in execution.
  always_comb begin
    wdata       = rdata_q;
    wr_en       = 1'b0;
    set_present = 1'b0;
    clr_present = 1'b0;
    res_o       = '0;
    cnt_inc     = (rdata_q.count == 8'hFF) ? rdata_q.count : rdata_q.count + 8'd1;
    pr          = add_penalty(rdata_q.score, cmd_i.penalty, cfg_i.threshold, rdata_q.noban);
    unique case (cmd_i.cls)
      CLS_ATTACH: begin
        wdata       = '0;
        wdata.noban = cmd_i.noban;
        wr_en       = 1'b1;
        set_present = 1'b1;
        res_o.found = 1'b1;
      end
      CLS_DETACH: begin
        clr_present = 1'b1;
        res_o.found = pres;
      end
      CLS_NONE: begin
        res_o = '0;
      end
      default: begin
        if (pres) begin
          unique case (cmd_i.cls)
            CLS_PENALIZE: begin
              wdata.score = pr.score;
              wdata.mark  = rdata_q.mark | pr.newly;
              res_o.disconnect = pr.newly;
              wr_en = 1'b1;
            end
            CLS_COUNT: begin
              if (!rdata_q.latched) begin
                wdata.count = cnt_inc;
                wr_en       = 1'b1;
                if (cnt_inc >= cfg_i.limit) begin
                  pr = add_penalty(rdata_q.score, cfg_i.penalty, cfg_i.threshold,
                                   rdata_q.noban);
                  wdata.latched    = 1'b1;
                  wdata.score      = pr.score;
                  wdata.mark       = rdata_q.mark | pr.newly;
                  res_o.disconnect = pr.newly;
                end
              end
            end
            CLS_RESET: begin
              wdata.count = 8'd0;
              wr_en       = 1'b1;
            end
            default: begin
              res_o.disconnect = rdata_q.mark && !rdata_q.noban;
            end
          endcase
          res_o.found              = 1'b1;
          res_o.score              = wdata.score;
          res_o.unconnecting_count = wdata.count;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (state_q == BK_EXEC) begin
      if (set_present) begin
        present_q[cmd_i.idx] <= 1'b1;
      end else if (clr_present) begin
        present_q[cmd_i.idx] <= 1'b0;
      end
    end
  end

  // Entry memory: one read port with registered data, one write port.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[cmd_i.idx];
    end
    if ((state_q == BK_EXEC) && wr_en) begin
      mem_q[cmd_i.idx] <= wdata;
    end
  end

endmodule

[rtl/pmst_result_queue.sv]
// Two-entry result queue that presents the oldest result on the output ports.
`timescale 1ns / 1ps
module pmst_result_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_push_i,
  input  pmst_pkg::res_t res_i,
  output logic           res_full_o,
  output logic           empty,
  input  logic           pop,
  output pmst_pkg::res_t res_o
);
  import pmst_pkg::*;

  res_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       take;

  assign empty      = (cnt_q == 2'd0);
  assign res_full_o = (cnt_q == 2'd2);
  assign take       = pop && !empty;
  assign res_o      = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = res_push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, res_push_i} - {1'b0, take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

[rtl/peer_misbehavior_score_table_unit.sv]
// Top level of the peer misbehavior score table: configuration registers and block wiring.
`timescale 1ns / 1ps
// The unit keeps one entry per peer (presence, no-ban flag, saturating 16-bit score,
// discourage mark, saturating unconnecting-message count and its latch) and executes one
// operation per input transfer, giving exactly one result transfer per item in order.
// Items are taken through push/full into a two-entry command queue, so the producer can
// keep pushing while the back end works; results wait in a two-entry queue read through
// empty/pop. The back end handles one item at a time: the registered read of the entry
// memory comes first, then the modify, write-back and result transfer, and it starts an
// item only when the result queue has room. Presence bits are cleared by reset at once,
// so no clearing pass is needed and items are accepted right after reset. Configuration
// registers (index 0 threshold, 1 unconnecting limit, 2 unconnecting penalty) are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while the unit
// is idle; writes to other indexes are ignored.
module peer_misbehavior_score_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op_i,
  input  logic [5:0]  peer_i,
  input  logic [7:0]  penalty_i,
  input  logic        noban_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic        disconnect_o,
  output logic [15:0] score_o,
  output logic [7:0]  unconnecting_count_o
);
  import pmst_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res_new;
  res_t res_head;

  // Configuration registers; a write to an unused index changes nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.limit     <= LIMIT_RST;
      cfg_q.penalty   <= PENALTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: cfg_q.threshold <= cfg_wdata_i;
        CFG_LIMIT:     cfg_q.limit     <= cfg_wdata_i[7:0];
        CFG_PENALTY:   cfg_q.penalty   <= cfg_wdata_i[7:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  // Front end: classification and the command queue.
  pmst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .peer_i      (peer_i),
    .penalty_i   (penalty_i),
    .noban_i     (noban_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: starts an item only when the result queue has room for it.
  pmst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  pmst_result_queue u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_new),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_head)
  );

  assign found_o              = res_head.found;
  assign disconnect_o         = res_head.disconnect;
  assign score_o              = res_head.score;
  assign unconnecting_count_o = res_head.unconnecting_count;

`ifndef ASSERT_OFF
  // The back end reserves result space before it reads, so the result queue never overflows.
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // Every command retired by the back end yields exactly one result transfer.
  a_pop_push_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop == res_push)
    else $error("command retire and result push out of step");

  // A command is never retired from an empty command queue.
  a_no_cmd_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // An accepted input is visible to the back end in the next cycle.
  a_accept_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> cmd_valid)
    else $error("accepted item not queued");
`endif

endmodule

[bench/peer_misbehavior_score_table_unit_tb.sv]
// Self-checking testbench of the peer misbehavior score table unit.
`timescale 1ns / 1ps
// The bench pushes operations into the unit and pops one result for each transfer. A
// behavioral copy of the peer table runs beside the unit and works out every result.
// The run has two parts. A short directed table comes first. It runs on the reset
// register values and covers every operation, absent peers, the lowest and highest
// peer indexes, a no-ban peer, the first threshold crossing, re-attaching a present
// peer, double detach and the unused op codes. Four random phases follow, each with
// its own register setting and its own stimulus shape:
//   - a general mix on a few peers with the reset register values;
//   - the lowest useful settings (threshold 1, limit 1, penalty 0);
//   - one hot peer under the highest settings, so that the score saturates and the
//     unconnecting count climbs to 255 before it latches;
//   - threshold and limit both zero.
// Idling follows the phases. First the producer side is idle 16% of the time and the
// consumer side 83%. Then the two are swapped, and in the last two phases neither side
// idles. At the start of the last phase the consumer stops popping for a long stretch,
// so the queues fill up and full holds the producer back.
module peer_misbehavior_score_table_unit_tb;
  import pmst_pkg::*;

  localparam int unsigned LATENCY_SLACK = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned NUM_ROWS      = 24;
  localparam int unsigned NUM_PHASES    = 4;

  // Clock, reset and every input of the unit start at known values.
  logic        clk_i                = 1'b0;
  logic        rst_ni               = 1'b0;
  logic        cfg_we_i             = 1'b0;
  logic [1:0]  cfg_idx_i            = CFG_THRESHOLD;
  logic [15:0] cfg_wdata_i          = '0;
  logic        push                 = 1'b0;
  logic        full;
  logic [2:0]  op_i                 = OP_QUERY;
  logic [5:0]  peer_i               = '0;
  logic [7:0]  penalty_i            = '0;
  logic        noban_i              = 1'b0;
  logic        empty;
  logic        pop                  = 1'b0;
  logic        found_o;
  logic        disconnect_o;
  logic [15:0] score_o;
  logic [7:0]  unconnecting_count_o;

  peer_misbehavior_score_table_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .push                (push),
    .full                (full),
    .op_i                (op_i),
    .peer_i              (peer_i),
    .penalty_i           (penalty_i),
    .noban_i             (noban_i),
    .empty               (empty),
    .pop                 (pop),
    .found_o             (found_o),
    .disconnect_o        (disconnect_o),
    .score_o             (score_o),
    .unconnecting_count_o(unconnecting_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // One row of the directed table. Where typed is set, the result is written out in the
  // row and replaces the computed one. Other rows are checked against the table copy.
  typedef struct {
    logic [2:0]  op;
    logic [5:0]  peer;
    logic [7:0]  pen;
    logic        nb;
    logic        typed;
    logic        found;
    logic        disc;
    logic [15:0] score;
    logic [7:0]  cnt;
  } dir_row_t;

  // Register setting, stimulus shape and idling of one random phase. The op weights are
  // percentages, and whatever is left over goes to the unused op codes.
  typedef struct {
    int unsigned n_items;
    int unsigned pool;
    int unsigned w_pen;
    int unsigned w_cnt;
    int unsigned w_rst;
    int unsigned w_qry;
    int unsigned w_att;
    int unsigned w_det;
    int unsigned hi_pen;
    int unsigned thr;
    int unsigned lim;
    int unsigned upen;
    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned hold;
  } phase_t;

  // Every row below runs with the reset values: threshold 100, limit 10, penalty 20.
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{OP_QUERY,    6'd0,  8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_PENALIZE, 6'd63, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_ATTACH,   6'd0,  8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd0,   8'd0},
    '{OP_ATTACH,   6'd63, 8'd0,   1'b1, 1'b1, 1'b1, 1'b0, 16'd0,   8'd0},
    '{OP_PENALIZE, 6'd0,  8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd0,   8'd0},
    '{OP_PENALIZE, 6'd0,  8'd99,  1'b0, 1'b1, 1'b1, 1'b0, 16'd99,  8'd0},
    '{OP_PENALIZE, 6'd0,  8'd1,   1'b0, 1'b1, 1'b1, 1'b1, 16'd100, 8'd0},
    '{OP_PENALIZE, 6'd0,  8'd255, 1'b0, 1'b1, 1'b1, 1'b0, 16'd355, 8'd0},
    '{OP_QUERY,    6'd0,  8'd0,   1'b0, 1'b1, 1'b1, 1'b1, 16'd355, 8'd0},
    '{OP_PENALIZE, 6'd63, 8'd255, 1'b0, 1'b1, 1'b1, 1'b0, 16'd255, 8'd0},
    '{OP_QUERY,    6'd63, 8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd255, 8'd0},
    '{OP_PENALIZE, 6'd63, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_COUNT,    6'd63, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_RESET,    6'd63, 8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd510, 8'd0},
    '{3'd6,        6'd0,  8'd0,   1'b0, 1'b1, 1'b1, 1'b1, 16'd355, 8'd0},
    '{3'd7,        6'd63, 8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd510, 8'd0},
    '{OP_DETACH,   6'd0,  8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd0,   8'd0},
    '{OP_DETACH,   6'd0,  8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_COUNT,    6'd0,  8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_ATTACH,   6'd63, 8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd0,   8'd0},
    '{OP_QUERY,    6'd63, 8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 16'd0,   8'd0},
    '{OP_RESET,    6'd5,  8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_ATTACH,   6'd5,  8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 16'd0,   8'd0},
    '{OP_PENALIZE, 6'd5,  8'hAA,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0,   8'd0}
  };

  phase_t phases [NUM_PHASES] = '{
    '{250, 8,  30, 25, 8,  17, 8, 7, 10, 100,   10,  20,  16, 83, 0},
    '{200, 4,  30, 30, 10, 15, 5, 5, 10, 1,     1,   0,   83, 16, 0},
    '{800, 1,  50, 42, 0,  6,  0, 0, 85, 65535, 255, 255, 0,  0,  0},
    '{200, 16, 30, 30, 8,  16, 8, 6, 20, 0,     0,   137, 0,  0,  1}
  };

  // Behavioral copy of the peer table and of the registers, updated at the clock edge
  // of each transfer into the unit and of each register write.
  logic        peer_present [PEERS];
  logic        peer_noban   [PEERS];
  logic [15:0] peer_score   [PEERS];
  logic        peer_mark    [PEERS];
  logic [7:0]  peer_unconn  [PEERS];
  logic        peer_latched [PEERS];
  logic [15:0] cfg_threshold = THRESHOLD_RST;
  logic [7:0]  cfg_limit     = LIMIT_RST;
  logic [7:0]  cfg_penalty   = PENALTY_RST;

  res_t        pending_results [$];
  int unsigned error_count  = 0;
  int unsigned result_index = 0;
  int unsigned cycle_count  = 0;

  // Typed result of the directed row that is being offered, if it has one.
  logic        typed_valid  = 1'b0;
  res_t        typed_result = '0;

  // Producer-side knowledge of which peers it has attached, used only to steer stimulus.
  logic        sent_attached [PEERS];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        stall_req     = 1'b0;
  logic        stall_done    = 1'b0;
  int unsigned stall_cycles  = 0;

  initial begin
    for (int i = 0; i < PEERS; i++) begin
      peer_present[i]  = 1'b0;
      peer_noban[i]    = 1'b0;
      peer_score[i]    = '0;
      peer_mark[i]     = 1'b0;
      peer_unconn[i]   = '0;
      peer_latched[i]  = 1'b0;
      sent_attached[i] = 1'b0;
    end
  end

  function automatic void clear_peer(input int unsigned p);
    peer_present[p] = 1'b0;
    peer_noban[p]   = 1'b0;
    peer_score[p]   = '0;
    peer_mark[p]    = 1'b0;
    peer_unconn[p]  = '0;
    peer_latched[p] = 1'b0;
  endfunction

  // Raises the score with saturation. Returns 1 only on the first crossing of the
  // threshold by a peer that may be banned, which also sets its discourage mark.
  function automatic logic charge_score(input int unsigned p, input logic [7:0] amount);
    int unsigned before_score;
    int unsigned raised;
    before_score = 32'(peer_score[p]);
    raised = before_score + 32'(amount);
    if (raised > 16'hFFFF) raised = 16'hFFFF;
    peer_score[p] = raised[15:0];
    if (raised >= cfg_threshold && before_score < cfg_threshold && !peer_noban[p]) begin
      peer_mark[p] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one operation to the table copy and returns the result the unit must give.
  function automatic res_t apply_peer_op(input logic [2:0] op, input logic [5:0] peer,
                                         input logic [7:0] pen, input logic nb);
    res_t        r;
    int unsigned p;
    p = 32'(peer);
    r = '0;
    if (op == OP_ATTACH) begin
      clear_peer(p);
      peer_present[p] = 1'b1;
      peer_noban[p]   = nb;
      r.found = 1'b1;
      return r;
    end
    if (op == OP_DETACH) begin
      r.found = peer_present[p];
      clear_peer(p);
      return r;
    end
    // Every other operation on an absent peer changes nothing and gives all zeros.
    if (!peer_present[p]) return r;
    r.found = 1'b1;
    case (op)
      OP_PENALIZE: begin
        r.disconnect = charge_score(p, pen);
      end
      OP_COUNT: begin
        // Once latched the count is frozen and the penalty is never charged again.
        if (!peer_latched[p]) begin
          if (peer_unconn[p] != 8'hFF) peer_unconn[p] = peer_unconn[p] + 8'd1;
          if (peer_unconn[p] >= cfg_limit) begin
            peer_latched[p] = 1'b1;
            r.disconnect = charge_score(p, cfg_penalty);
          end
        end
      end
      OP_RESET: begin
        peer_unconn[p] = '0;
      end
      default: begin
        // Query, and the unused op codes that behave like it.
        r.disconnect = peer_mark[p] && !peer_noban[p];
      end
    endcase
    r.score = peer_score[p];
    r.unconnecting_count = peer_unconn[p];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_error($sformatf("result %0d field %s: got %0d, expected %0d",
                           result_index, name, got, want));
  endtask

  // Watches both handshakes and the register port at the rising edge, where the unit
  // samples them. Registers and the table copy change in the same order as in the unit.
  always @(posedge clk_i) begin
    res_t want;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: cfg_threshold = cfg_wdata_i;
        CFG_LIMIT:     cfg_limit = cfg_wdata_i[7:0];
        CFG_PENALTY:   cfg_penalty = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
    if (push && !full) begin
      want = apply_peer_op(op_i, peer_i, penalty_i, noban_i);
      if (typed_valid) want = typed_result;
      pending_results.push_back(want);
    end
    if (pop && !empty) begin
      if (pending_results.size() == 0) begin
        flag_error("result transfer with no result outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("found", 32'(found_o), 32'(want.found));
        check_field("disconnect", 32'(disconnect_o), 32'(want.disconnect));
        check_field("score", 32'(score_o), 32'(want.score));
        check_field("unconnecting_count", 32'(unconnecting_count_o),
                    32'(want.unconnecting_count));
      end
      result_index++;
    end
  end

  // The consumer changes pop at the falling edge. Outside the long hold-off it idles
  // at the rate of the current phase.
  always @(negedge clk_i) begin
    if (stall_req && !stall_done) begin
      pop <= 1'b0;
      if (stall_cycles == HOLD_CYCLES - 1) stall_done <= 1'b1;
      stall_cycles <= stall_cycles + 1;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one item, with random idle cycles first, and returns at the falling edge
  // after its transfer. push stays high so the next item can follow back to back.
  task automatic send_item(input logic [2:0] op, input logic [5:0] peer,
                           input logic [7:0] pen, input logic nb,
                           input logic typed, input res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    op_i         <= op;
    peer_i       <= peer;
    penalty_i    <= pen;
    noban_i      <= nb;
    typed_valid  <= typed;
    typed_result <= want;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops offering, waits for every outstanding result, then waits out the LATENCY_SLACK
  // margin, so that the unit is idle before any register write.
  task automatic settle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (LATENCY_SLACK) @(negedge clk_i);
  endtask

  task automatic program_config(input int unsigned thr, input int unsigned lim,
                                input int unsigned upen);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_THRESHOLD;
    cfg_wdata_i <= thr[15:0];
    @(negedge clk_i);
    cfg_idx_i   <= CFG_LIMIT;
    cfg_wdata_i <= {8'd0, lim[7:0]};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PENALTY;
    cfg_wdata_i <= {8'd0, upen[7:0]};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Builds and sends one random item of a phase. Most items address a small pool of
  // peers, and a peer that is not attached is almost always attached first, so that
  // scores and counts build up. A few items are noise over the whole field ranges.
  task automatic send_random_item(input phase_t ph);
    logic [2:0]  op;
    logic [5:0]  peer;
    logic [7:0]  pen;
    logic        nb;
    int unsigned pick;
    if ($urandom_range(99) < 8) begin
      op   = 3'($urandom_range(7));
      peer = 6'($urandom_range(63));
      pen  = 8'($urandom_range(255));
      nb   = 1'($urandom_range(1));
    end else begin
      peer = 6'($urandom_range(ph.pool - 1));
      pick = $urandom_range(99);
      if (!sent_attached[peer] && $urandom_range(99) < 90) op = OP_ATTACH;
      else if (pick < ph.w_pen) op = OP_PENALIZE;
      else if (pick < ph.w_pen + ph.w_cnt) op = OP_COUNT;
      else if (pick < ph.w_pen + ph.w_cnt + ph.w_rst) op = OP_RESET;
      else if (pick < ph.w_pen + ph.w_cnt + ph.w_rst + ph.w_qry) op = OP_QUERY;
      else if (pick < ph.w_pen + ph.w_cnt + ph.w_rst + ph.w_qry + ph.w_att) op = OP_ATTACH;
      else if (pick < ph.w_pen + ph.w_cnt + ph.w_rst + ph.w_qry + ph.w_att + ph.w_det)
        op = OP_DETACH;
      else op = 3'd6 + 3'($urandom_range(1));
      pen = ($urandom_range(99) < ph.hi_pen) ? 8'hFF : 8'($urandom_range(255));
      nb  = ($urandom_range(99) < 25);
    end
    if (op == OP_ATTACH) sent_attached[peer] = 1'b1;
    else if (op == OP_DETACH) sent_attached[peer] = 1'b0;
    send_item(op, peer, pen, nb, 1'b0, '0);
  endtask

  initial begin
    res_t typed_want;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table on the reset register values, with no idling.
    foreach (dir_rows[k]) begin
      typed_want = '{found: dir_rows[k].found, disconnect: dir_rows[k].disc,
                     score: dir_rows[k].score, unconnecting_count: dir_rows[k].cnt};
      if (dir_rows[k].op == OP_ATTACH) sent_attached[dir_rows[k].peer] = 1'b1;
      else if (dir_rows[k].op == OP_DETACH) sent_attached[dir_rows[k].peer] = 1'b0;
      send_item(dir_rows[k].op, dir_rows[k].peer, dir_rows[k].pen, dir_rows[k].nb,
                dir_rows[k].typed, typed_want);
    end

    foreach (phases[n]) begin
      settle();
      program_config(phases[n].thr, phases[n].lim, phases[n].upen);
      send_idle_pct = phases[n].send_idle;
      recv_idle_pct <= phases[n].recv_idle;
      if (phases[n].hold != 0) stall_req <= 1'b1;
      repeat (phases[n].n_items) send_random_item(phases[n]);
    end

    settle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
